### sv/rbuc_pkg.sv
// ----------------------------------------------------------------------------
// rbuc_pkg
// Shared types and constants of the record block/unblock converter.
// ----------------------------------------------------------------------------
package rbuc_pkg;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [5:0]  COL_MAX   = 6'd63;
    localparam logic [15:0] TRUNC_MAX = 16'hFFFF;

    // conversion modes; the unused code behaves as raw
    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_BLOCK   = 2'd1;
    localparam logic [1:0] MODE_UNBLOCK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_CASE_MODE  = 2'd1;
    localparam logic [1:0] REG_SWAP_BYTES = 2'd2;
    localparam logic [1:0] REG_RECORD_LEN = 2'd3;

    localparam logic [5:0] RECORD_LEN_RESET = 6'd32;

    // phases of one operation, in the order the back end runs them
    localparam logic [2:0] LV_FLUSH = 3'd0;
    localparam logic [2:0] LV_PAD   = 3'd1;
    localparam logic [2:0] LV_WR    = 3'd2;
    localparam logic [2:0] LV_CHR   = 3'd3;
    localparam logic [2:0] LV_NL    = 3'd4;
    localparam logic [2:0] LV_END   = 3'd5;

    localparam int NUM_OPS = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] case_mode;
        logic       swap_bytes;
        logic [5:0] record_len;
    } cfg_t;

    // one byte conversion: flush held whitespace, pad, store whitespace,
    // emit the byte, emit a newline
    typedef struct packed {
        logic [5:0] flush_cnt;
        logic [5:0] pad_cnt;
        logic       wr_en;
        logic [5:0] wr_idx;
        logic [7:0] wr_data;
        logic       chr_en;
        logic [7:0] chr;
        logic       nl_en;
    } op_t;

    // work caused by one input item; slot 2 is the stream-end close
    typedef struct packed {
        op_t [NUM_OPS-1:0] ops;
        logic [15:0]       trunc;
    } step_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FRD,
        BK_FEM,
        BK_PAD,
        BK_WR,
        BK_CHR,
        BK_NL
    } bk_state_t;

endpackage

### sv/rbuc_ram.sv
// ----------------------------------------------------------------------------
// rbuc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbuc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/rbuc_queue.sv
// ----------------------------------------------------------------------------
// rbuc_queue
// Two-entry queue of step records between the front and back ends.
// ----------------------------------------------------------------------------
module rbuc_queue
    import rbuc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  step_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output step_t head
);

    step_t      mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rp_reg];

endmodule

### sv/rbuc_front.sv
// ----------------------------------------------------------------------------
// rbuc_front
// Accepts input bytes, does pair swapping and case folding, tracks column,
// truncation and pending-whitespace state, and queues a step record for each item that has work.
// ----------------------------------------------------------------------------
module rbuc_front
    import rbuc_pkg::*;
#(
    parameter int RECORD_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // block_end
    input  logic       s_tuser,     // [0] stream_end
    output logic       push,
    output step_t      push_data,
    input  logic       q_full
);

    localparam logic [5:0] REC_MAX_W = 6'(RECORD_MAX);

    typedef struct packed {
        logic [5:0]  column;
        logic [15:0] trunc;
        logic [5:0]  pend;
    } fst_t;

    typedef struct packed {
        op_t  op;
        fst_t st;
    } opres_t;

    logic [5:0]  column_reg, column_next;
    logic [15:0] trunc_reg, trunc_next;
    logic [5:0]  pend_reg, pend_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;

    logic        accept;
    logic        ends;
    logic [5:0]  len;
    logic [7:0]  first_b, second_b;
    fst_t        st0, st_a, st_b;
    opres_t      r0, r1, r2;
    step_t       step;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic [1:0] cm);
        logic [7:0] r;
        r = c;
        if (cm[0]) begin
            if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
        end else if (cm[1]) begin
            if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // close a block-mode line: count it if cut, else pad to the record length
    function automatic opres_t close_line(input fst_t s, input logic [5:0] ln);
        opres_t r;
        r    = '0;
        r.st = s;
        if (s.column > ln) begin
            if (s.trunc != TRUNC_MAX) r.st.trunc = s.trunc + 16'd1;
        end else begin
            r.op.pad_cnt = ln - s.column;
        end
        r.st.column = 6'd0;
        return r;
    endfunction

    function automatic opres_t proc_op(input logic [7:0] c_in, input fst_t s,
                                       input cfg_t cf, input logic [5:0] ln);
        opres_t     r;
        logic [7:0] c;
        logic [5:0] col;
        logic [5:0] pend;
        r    = '0;
        r.st = s;
        c    = fold(c_in, cf.case_mode);
        unique case (cf.mode)
            MODE_BLOCK: begin
                if (c == CH_NL) begin
                    r = close_line(s, ln);
                end else begin
                    r.op.chr_en = (s.column < ln);
                    r.op.chr    = c;
                    if (s.column <= ln && s.column != COL_MAX) begin
                        r.st.column = s.column + 6'd1;
                    end
                end
            end
            MODE_UNBLOCK: begin
                col  = (s.column != COL_MAX) ? s.column + 6'd1 : s.column;
                pend = s.pend;
                if (is_ws(c)) begin
                    if (pend >= REC_MAX_W) begin
                        r.op.flush_cnt = pend;
                        pend           = 6'd0;
                    end
                    r.op.wr_en   = 1'b1;
                    r.op.wr_idx  = pend;
                    r.op.wr_data = c;
                    pend         = pend + 6'd1;
                end else begin
                    r.op.flush_cnt = pend;
                    pend           = 6'd0;
                    r.op.chr_en    = 1'b1;
                    r.op.chr       = c;
                end
                if (col >= ln) begin
                    pend       = 6'd0;
                    r.op.nl_en = 1'b1;
                    col        = 6'd0;
                end
                r.st.column = col;
                r.st.pend   = pend;
            end
            MODE_RAW: begin
                r.op.chr_en = 1'b1;
                r.op.chr    = c;
            end
            default: begin
                r.op.chr_en = 1'b1;
                r.op.chr    = c;
            end
        endcase
        return r;
    endfunction

    // stream end closes a partial line or record
    function automatic opres_t close_op(input fst_t s, input cfg_t cf, input logic [5:0] ln);
        opres_t r;
        r    = '0;
        r.st = s;
        if (cf.mode == MODE_BLOCK) begin
            if (s.column != 6'd0) r = close_line(s, ln);
        end else if (cf.mode == MODE_UNBLOCK) begin
            if (s.column != 6'd0 || s.pend != 6'd0) begin
                r.op.nl_en  = 1'b1;
                r.st.pend   = 6'd0;
                r.st.column = 6'd0;
            end
        end
        return r;
    endfunction

    function automatic logic op_busy(input op_t op);
        return (op.flush_cnt != 6'd0) || (op.pad_cnt != 6'd0) || op.wr_en
               || op.chr_en || op.nl_en;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (cfg.record_len == 6'd0) begin
            len = 6'd1;
        end else if (cfg.record_len > REC_MAX_W) begin
            len = REC_MAX_W;
        end else begin
            len = cfg.record_len;
        end

        ends            = s_tlast || s_tuser;
        st0             = '{column: column_reg, trunc: trunc_reg, pend: pend_reg};
        step            = '0;
        r0              = '0;
        r1              = '0;
        r2              = '0;
        first_b         = cfg.swap_bytes ? s_tdata : held_byte_reg;
        second_b        = cfg.swap_bytes ? held_byte_reg : s_tdata;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        st_a            = st0;

        if (held_valid_reg) begin
            r0              = proc_op(first_b, st0, cfg, len);
            r1              = proc_op(second_b, r0.st, cfg, len);
            step.ops[0]     = r0.op;
            step.ops[1]     = r1.op;
            st_a            = r1.st;
            held_valid_next = 1'b0;
        end else if (cfg.swap_bytes && !ends) begin
            // hold the first byte of a pair for its partner
            held_byte_next  = s_tdata;
            held_valid_next = 1'b1;
        end else begin
            r0          = proc_op(s_tdata, st0, cfg, len);
            step.ops[0] = r0.op;
            st_a        = r0.st;
        end

        st_b = st_a;
        if (s_tuser) begin
            r2          = close_op(st_a, cfg, len);
            step.ops[2] = r2.op;
            st_b        = r2.st;
        end
        step.trunc = st_b.trunc;

        column_next = st_b.column;
        trunc_next  = st_b.trunc;
        pend_next   = st_b.pend;

        push_data = step;
        push      = accept && (op_busy(step.ops[0]) || op_busy(step.ops[1])
                               || op_busy(step.ops[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= 6'd0;
            trunc_reg      <= 16'd0;
            pend_reg       <= 6'd0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'd0;
        end else if (accept) begin
            column_reg     <= column_next;
            trunc_reg      <= trunc_next;
            pend_reg       <= pend_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
        end
    end

endmodule

### sv/rbuc_back.sv
// ----------------------------------------------------------------------------
// rbuc_back
// Runs queued step records: flushes and stores held whitespace, pads records,
// emits bytes and newlines into the output register.
// ----------------------------------------------------------------------------
module rbuc_back
    import rbuc_pkg::*;
#(
    parameter int RECORD_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  step_t       q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_byte, [23:8] truncated_count
    output logic        m_tlast     // last_of_run
);

    localparam int AW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;

    typedef struct packed {
        logic       found;
        logic [1:0] oi;
        bk_state_t  st;
        logic       more_out;
    } pos_t;

    bk_state_t   state_reg, state_next;
    logic [1:0]  oi_reg, oi_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] trunc_reg;

    op_t         cur;
    pos_t        nxt;
    logic [1:0]  srch_oi;
    logic [2:0]  srch_lv;
    logic        out_free;
    logic        load;
    logic [7:0]  ld_byte;
    logic        ld_last;
    logic        finish;
    logic        ram_rd_en;
    logic        ram_wr_en;
    logic [7:0]  ram_rd_data;

    function automatic logic applies(input op_t op, input logic [2:0] lv);
        logic r;
        case (lv)
            LV_FLUSH: r = (op.flush_cnt != 6'd0);
            LV_PAD:   r = (op.pad_cnt != 6'd0);
            LV_WR:    r = op.wr_en;
            LV_CHR:   r = op.chr_en;
            LV_NL:    r = op.nl_en;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic bk_state_t lv_state(input logic [2:0] lv);
        bk_state_t r;
        case (lv)
            LV_FLUSH: r = BK_FRD;
            LV_PAD:   r = BK_PAD;
            LV_WR:    r = BK_WR;
            LV_CHR:   r = BK_CHR;
            default:  r = BK_NL;
        endcase
        return r;
    endfunction

    // first phase at or after (oi, lv) that has work, and whether any
    // byte is still to come from that point on
    function automatic pos_t find_next(input step_t st, input logic [1:0] oi,
                                       input logic [2:0] lv);
        pos_t r;
        logic hit;
        int   j;
        int   l;
        r          = '0;
        r.st       = BK_IDLE;
        for (j = 0; j < NUM_OPS; j++) begin
            for (l = 0; l < 5; l++) begin
                if ((2'(j) > oi) || (2'(j) == oi && 3'(l) >= lv)) begin
                    hit = applies(st.ops[j], 3'(l));
                    if (hit && !r.found) begin
                        r.found = 1'b1;
                        r.oi    = 2'(j);
                        r.st    = lv_state(3'(l));
                    end
                    if (hit && 3'(l) != LV_WR) r.more_out = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign cur      = q_head.ops[oi_reg];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (state_reg)
            BK_IDLE: begin
                srch_oi = 2'd0;
                srch_lv = LV_FLUSH;
            end
            BK_FRD, BK_FEM: begin
                srch_oi = oi_reg;
                srch_lv = LV_PAD;
            end
            BK_PAD: begin
                srch_oi = oi_reg;
                srch_lv = LV_WR;
            end
            BK_WR: begin
                srch_oi = oi_reg;
                srch_lv = LV_CHR;
            end
            BK_CHR: begin
                srch_oi = oi_reg;
                srch_lv = LV_NL;
            end
            BK_NL: begin
                srch_oi = oi_reg;
                srch_lv = LV_END;
            end
            default: begin
                srch_oi = 2'd0;
                srch_lv = LV_FLUSH;
            end
        endcase
        nxt = find_next(q_head, srch_oi, srch_lv);
    end

    always_comb begin
        state_next = state_reg;
        oi_next    = oi_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        ld_byte    = CH_SP;
        ld_last    = 1'b0;
        finish     = 1'b0;
        ram_rd_en  = 1'b0;
        ram_wr_en  = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) finish = 1'b1;
            end
            BK_FRD: begin
                ram_rd_en  = 1'b1;
                state_next = BK_FEM;
            end
            BK_FEM: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = ram_rd_data;
                    if (cnt_reg == cur.flush_cnt - 6'd1) begin
                        ld_last = !nxt.more_out;
                        finish  = 1'b1;
                    end else begin
                        cnt_next   = cnt_reg + 6'd1;
                        state_next = BK_FRD;
                    end
                end
            end
            BK_PAD: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_SP;
                    if (cnt_reg == cur.pad_cnt - 6'd1) begin
                        ld_last = !nxt.more_out;
                        finish  = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            BK_WR: begin
                ram_wr_en = 1'b1;
                finish    = 1'b1;
            end
            BK_CHR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = cur.chr;
                    ld_last = !nxt.more_out;
                    finish  = 1'b1;
                end
            end
            BK_NL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_NL;
                    ld_last = !nxt.more_out;
                    finish  = 1'b1;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // advance to the next phase with work, or retire the step
        if (finish) begin
            if (nxt.found) begin
                state_next = nxt.st;
                oi_next    = nxt.oi;
                cnt_next   = 6'd0;
            end else begin
                q_pop      = 1'b1;
                state_next = BK_IDLE;
            end
        end

        m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            oi_reg       <= 2'd0;
            cnt_reg      <= 6'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oi_reg       <= oi_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= ld_byte;
            last_reg  <= ld_last;
            trunc_reg <= q_head.trunc;
        end
    end

    rbuc_ram #(
        .WIDTH (8),
        .DEPTH (RECORD_MAX)
    ) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (cur.wr_idx[AW-1:0]),
        .wr_data (cur.wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {trunc_reg, byte_reg};
    assign m_tlast  = last_reg;

endmodule

### sv/record_block_unblock_converter.sv
// ----------------------------------------------------------------------------
// record_block_unblock_converter
// Byte-stream converter: pair swap, case fold, raw/block/unblock records.
// ----------------------------------------------------------------------------
// The front end takes one input item per cycle while its two-entry step queue
// has room, and turns each item into up to three queued operations. The back
// end picks up a step, then emits its output bytes phase by phase. A
// whitespace byte flushed from the pending store (RAM with registered read)
// is read and then emitted, and a whitespace byte stored is written to it.
// Long pads and whitespace flushes can fill the queue and so hold the input.
// Each output item carries the truncation count as it stands after the
// whole input item, and m_tlast marks the last output byte of it.
// Configuration writes are taken in any cycle and are meant for idle periods.
module record_block_unblock_converter
    import rbuc_pkg::*;
#(
    parameter int RECORD_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // block_end
    input  logic        s_tuser,    // [0] stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_byte, [23:8] truncated_count
    output logic        m_tlast     // last_of_run
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_push;
    step_t q_push_data;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    step_t q_head;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:       cfg_next.mode       = cfg_data[1:0];
                REG_CASE_MODE:  cfg_next.case_mode  = cfg_data[1:0];
                REG_SWAP_BYTES: cfg_next.swap_bytes = cfg_data[0];
                REG_RECORD_LEN: cfg_next.record_len = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= MODE_RAW;
            cfg_reg.case_mode  <= 2'd0;
            cfg_reg.swap_bytes <= 1'b0;
            cfg_reg.record_len <= RECORD_LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rbuc_front #(
        .RECORD_MAX (RECORD_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full)
    );

    rbuc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    rbuc_back #(
        .RECORD_MAX (RECORD_MAX)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### dv/rbuc_checker.sv
// ----------------------------------------------------------------------------
// rbuc_checker
// Watches the configuration, input and output channels of the converter,
// predicts the output bytes of every accepted input item and compares them,
// field by field and in order, with what the converter delivers.
// ----------------------------------------------------------------------------
module rbuc_checker
    import rbuc_pkg::*;
#(
    parameter int RECORD_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // block_end
    input  logic        s_tuser,    // [0] stream_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] out_byte, [23:8] truncated_count
    input  logic        m_tlast,    // last_of_run
    output int unsigned fail_count,
    output int unsigned results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTES_PER_ITEM_MAX = 64;
    localparam int MISMATCH_REPORTS   = 10;

    typedef struct {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic [15:0] trunc_count;
    } conv_byte_t;

    conv_byte_t expected_bytes[$];
    logic [7:0] item_bytes[$];

    // configuration as the converter sees it
    logic [1:0] cur_mode;
    logic [1:0] cur_case;
    logic       cur_swap;
    logic [5:0] cur_len;

    // conversion state
    logic [5:0]  column;
    logic [15:0] trunc_cnt;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic [7:0]  space_buf[RECORD_MAX];
    logic [5:0]  space_cnt;

    function automatic void put_byte(logic [7:0] b);
        if (item_bytes.size() < BYTES_PER_ITEM_MAX)
            item_bytes.push_back(b);
    endfunction

    function automatic logic [5:0] record_size();
        if (cur_len == 6'd0)
            return 6'd1;
        if (cur_len > RECORD_MAX)
            return 6'(RECORD_MAX);
        return cur_len;
    endfunction

    function automatic void flush_spaces();
        for (int i = 0; i < space_cnt && i < RECORD_MAX; i++)
            put_byte(space_buf[i]);
        space_cnt = '0;
    endfunction

    // pad a short line with spaces, or count a cut one
    function automatic void end_line();
        logic [5:0] len;
        len = record_size();
        if (column > len) begin
            if (trunc_cnt != TRUNC_MAX)
                trunc_cnt++;
        end else begin
            while (column < len) begin
                put_byte(CH_SP);
                column++;
            end
        end
        column = '0;
    endfunction

    // drop held whitespace and terminate the line
    function automatic void end_record();
        space_cnt = '0;
        put_byte(CH_NL);
        column = '0;
    endfunction

    function automatic void convert_byte(logic [7:0] c);
        logic [7:0] ch;
        logic [5:0] len;
        len = record_size();
        ch  = c;
        // lower case wins when both fold bits are set
        if (cur_case[0]) begin
            if (ch >= "A" && ch <= "Z")
                ch = ch + 8'd32;
        end else if (cur_case[1]) begin
            if (ch >= "a" && ch <= "z")
                ch = ch - 8'd32;
        end
        case (cur_mode)
            MODE_BLOCK: begin
                if (ch == CH_NL) begin
                    end_line();
                end else begin
                    if (column < len)
                        put_byte(ch);
                    if (column <= len && column < COL_MAX)
                        column++;
                end
            end
            MODE_UNBLOCK: begin
                if (column < COL_MAX)
                    column++;
                // whitespace: space, or tab through carriage return
                if (ch == CH_SP || (ch >= 8'h09 && ch <= 8'h0D)) begin
                    if (space_cnt >= RECORD_MAX)
                        flush_spaces();
                    space_buf[space_cnt] = ch;
                    space_cnt++;
                end else begin
                    flush_spaces();
                    put_byte(ch);
                end
                if (column >= len)
                    end_record();
            end
            default: put_byte(ch);
        endcase
    endfunction

    function automatic void predict_conversion(logic [7:0] b, logic blk_end, logic strm_end);
        conv_byte_t r;
        logic       ends;
        ends = blk_end || strm_end;
        item_bytes.delete();
        if (held_valid) begin
            if (cur_swap) begin
                convert_byte(b);
                convert_byte(held_byte);
            end else begin
                convert_byte(held_byte);
                convert_byte(b);
            end
            held_valid = 1'b0;
        end else if (cur_swap && !ends) begin
            held_byte  = b;
            held_valid = 1'b1;
        end else begin
            convert_byte(b);
        end
        if (strm_end) begin
            if (cur_mode == MODE_BLOCK) begin
                if (column > 0)
                    end_line();
            end else if (cur_mode == MODE_UNBLOCK) begin
                if (column > 0 || space_cnt > 0)
                    end_record();
            end
        end
        foreach (item_bytes[k]) begin
            r.out_byte    = item_bytes[k];
            r.last_of_run = (k == item_bytes.size() - 1);
            r.trunc_count = trunc_cnt;
            expected_bytes.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        conv_byte_t want;
        if (!aresetn) begin
            cur_mode   = MODE_RAW;
            cur_case   = '0;
            cur_swap   = 1'b0;
            cur_len    = RECORD_LEN_RESET;
            column     = '0;
            trunc_cnt  = '0;
            held_byte  = '0;
            held_valid = 1'b0;
            space_cnt  = '0;
            expected_bytes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:       cur_mode = cfg_data[1:0];
                    REG_CASE_MODE:  cur_case = cfg_data[1:0];
                    REG_SWAP_BYTES: cur_swap = cfg_data[0];
                    REG_RECORD_LEN: cur_len  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_conversion(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    if (fail_count < MISMATCH_REPORTS)
                        $display("%t: unexpected output byte %h last %b count %0d", $realtime,
                                 m_tdata[7:0], m_tlast, m_tdata[23:8]);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== want.out_byte || m_tlast !== want.last_of_run ||
                        m_tdata[23:8] !== want.trunc_count) begin
                        if (fail_count < MISMATCH_REPORTS)
                            $display("%t: expected byte %h last %b count %0d, got byte %h last %b count %0d",
                                     $realtime, want.out_byte, want.last_of_run, want.trunc_count,
                                     m_tdata[7:0], m_tlast, m_tdata[23:8]);
                        fail_count++;
                    end
                end
            end
        end
        results_due = expected_bytes.size();
    end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the record block/unblock converter: directed items for the
// corner cases of each mode, then random phases of text-like byte streams
// under changing settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_top;
    import rbuc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REC_MAX        = 32;
    localparam int ITEM_TARGET    = 235;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 500000;

    localparam logic [1:0] CASE_KEEP  = 2'd0;
    localparam logic [1:0] CASE_LOWER = 2'd1;
    localparam logic [1:0] CASE_UPPER = 2'd2;
    localparam logic [1:0] CASE_BOTH  = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] in_byte
    logic        s_tlast;    // block_end
    logic        s_tuser;    // [0] stream_end
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] out_byte, [23:8] truncated_count
    logic        m_tlast;    // last_of_run

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned cycle_cnt;
    int          items_sent;
    int          phase_cnt;
    int          burst_left;
    bit          rx_hold_req;

    record_block_unblock_converter #(.RECORD_MAX(REC_MAX)) dut (.*);

    rbuc_checker #(.RECORD_MAX(REC_MAX)) u_checker (.*);

    always begin
        #2 aclk = 1'b0;
        #2 aclk = 1'b1;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_cnt, results_due);
            $display("simulation failed");
            $finish;
        end
    end

    // output side: switch stall pattern now and then, long hold-off on request
    initial begin
        int rx_cyc;
        int rx_style;
        int hold_left;
        rx_cyc    = 0;
        rx_style  = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            rx_cyc++;
            if (rx_cyc % 64 == 0)
                rx_style = $urandom_range(0, 3);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= (rx_cyc % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_item(logic [7:0] b, bit blk_end, bit strm_end);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= blk_end;
        s_tuser  <= strm_end;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // block and stream end flags go on the last character only
    task automatic send_str(string s, bit blk_end, bit strm_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], blk_end && i == s.len() - 1, strm_end && i == s.len() - 1);
    endtask

    // hold input until all predicted bytes are out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(logic [1:0] md, logic [1:0] cs, bit sw, logic [5:0] len);
        cfg_write(REG_MODE, {4'b0, md});
        cfg_write(REG_CASE_MODE, {4'b0, cs});
        cfg_write(REG_SWAP_BYTES, {5'b0, sw});
        cfg_write(REG_RECORD_LEN, len);
        cfg_valid <= 1'b0;
        phase_cnt++;
    endtask

    function automatic logic [7:0] random_space();
        return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CH_SP;
    endfunction

    // mostly letters and whitespace, some line ends, some arbitrary bytes
    function automatic logic [7:0] pick_byte(logic [1:0] md);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'($urandom_range(0, 255));
        if (md == MODE_BLOCK && r < 27)
            return CH_NL;
        if (r < 40)
            return random_space();
        if (r < 45)
            return 8'($urandom_range("0", "9"));
        if (r < 70)
            return 8'($urandom_range("A", "Z"));
        return 8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [5:0] pick_len(int ph);
        int r;
        case (ph)
            0: return 6'd0;
            1: return 6'd63;
            2: return 6'd1;
            3: return 6'd32;
            default: ;
        endcase
        r = $urandom_range(0, 9);
        if (r < 5)
            return 6'($urandom_range(1, 8));
        if (r < 8)
            return 6'($urandom_range(9, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    initial begin
        logic [1:0] md;
        int         n;
        int         ph;
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_MODE;
        cfg_data   <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        s_tuser    <= 1'b0;
        items_sent  = 0;
        phase_cnt   = 0;
        burst_left  = 0;
        rx_hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: raw copy of the byte extremes
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        drain();

        // pair swap with an odd block end, then leave a byte held
        apply_config(MODE_RAW, CASE_LOWER, 1'b1, 6'd32);
        send_str("AbC", 1'b1, 1'b0);
        send_str("X", 1'b0, 1'b0);
        drain();

        // swap off while a byte is held: held byte goes first
        apply_config(MODE_RAW, CASE_UPPER, 1'b0, 6'd32);
        send_str("y", 1'b0, 1'b0);
        drain();

        // exact fit, a cut line ending with the stream, a padded partial line
        apply_config(MODE_BLOCK, CASE_BOTH, 1'b0, 6'd3);
        send_str("ABC\n", 1'b0, 1'b0);
        send_str("DEFG\n", 1'b0, 1'b1);
        send_str("h", 1'b0, 1'b1);
        drain();

        // trailing whitespace dropped, stream end on held whitespace only
        apply_config(MODE_UNBLOCK, CASE_KEEP, 1'b0, 6'd3);
        send_str("a\tb c ", 1'b0, 1'b0);
        send_item(8'h0D, 1'b0, 1'b1);
        drain();

        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            if (ph == 5) begin
                // grow held whitespace past a full store across a block-mode line end
                apply_config(MODE_BLOCK, CASE_KEEP, 1'b0, 6'd32);
                send_item(CH_NL, 1'b0, 1'b0);
                drain();
                apply_config(MODE_UNBLOCK, CASE_KEEP, 1'b0, 6'd32);
                repeat (20) send_item(random_space(), 1'b0, 1'b0);
                drain();
                apply_config(MODE_BLOCK, CASE_KEEP, 1'b0, 6'd32);
                send_item(CH_NL, 1'b0, 1'b0);
                drain();
                apply_config(MODE_UNBLOCK, CASE_KEEP, 1'b0, 6'd32);
                repeat (14) send_item(random_space(), 1'b0, 1'b0);
                send_item("z", 1'b0, 1'b1);
                drain();
            end
            md = (ph == 2) ? MODE_RAW : 2'($urandom_range(0, 3));
            apply_config(md, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         pick_len(ph));
            // stall the output while input keeps coming
            if (ph == 2)
                rx_hold_req = 1'b1;
            n = (ph == 2) ? 30 : $urandom_range(8, 30);
            for (int i = 0; i < n; i++)
                send_item(pick_byte(md), $urandom_range(0, 5) == 0,
                          $urandom_range(0, 24) == 0 || (i == n - 1 && $urandom_range(0, 1)));
            drain();
            ph++;
        end

        $display("run covered %0d input items over %0d register settings", items_sent, phase_cnt);
        if (fail_count == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d bytes still due", fail_count, results_due);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
